// ===== hdl/wfs_pkg.sv =====
// Shared types and constants for the winnowing fingerprint selector.
// Used by wfs_ctrl, wfs_datapath and winnowing_fingerprint_select_top.
`default_nettype none

package wfs_pkg;

    localparam int KGRAM_LEN_DEF  = 5;
    localparam int WINDOW_LEN_DEF = 4;
    localparam int POS_BITS       = 24;

    localparam int HASH_W   = 31;
    localparam int BASE_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W    = 31;
    localparam int REDW     = 48;
    localparam int RCNT_W   = 6;

    localparam logic [HASH_W-1:0] HASH_SENTINEL = {HASH_W{1'b1}};

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HASH_BASE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HASH_MODULUS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_POWER   = 2'd2;

    localparam logic [BASE_W-1:0] HASH_BASE_RST    = 16'd31;
    localparam logic [HASH_W-1:0] HASH_MODULUS_RST = 31'd1000000007;
    localparam logic [HASH_W-1:0] BASE_POWER_RST   = 31'd923521;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       doc_start;
    } in_item_t;

    typedef struct packed {
        logic [HASH_W-1:0]   fp_hash;
        logic [POS_BITS-1:0] fp_position;
    } out_item_t;

    // Operand of the serial reducer
    typedef enum logic [1:0] {
        SRC_POW  = 2'd0,
        SRC_CUR  = 2'd1,
        SRC_PROD = 2'd2
    } red_src_t;

    typedef struct packed {
        logic     load;
        logic     red_start;
        red_src_t red_src;
        logic     mul1;
        logic     cap_h;
        logic     subc;
        logic     mul2;
        logic     cap_fin;
        logic     upd;
        logic     scan_rd;
        logic     scan_cmp;
        logic     emit;
    } cmd_t;

    typedef struct packed {
        logic red_busy;
        logic roll;
        logic kgram_full;
        logic min_hit;
        logic new_le;
        logic scan_last;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// ===== hdl/winnowing_fingerprint_select_top.sv =====
// Top level of the winnowing fingerprint selector: sequencer plus datapath.
// Depends on wfs_pkg, wfs_ctrl and wfs_datapath.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_stall  | in_data   (text_byte, doc_start)
//   out     | output    | out_valid / out_stall| out_data  (fp_hash, fp_position)
//   cfg     | input     | cfg_write_en         | cfg_index, cfg_data
//
// Each byte runs three modular reductions (four once KGRAM_LEN bytes are in) plus
// control states, and a rescan of WINDOW_LEN-1 slots when the minimum leaves the window.
// The bit-serial reducer, 48 steps per modular reduction, sets the processing time.
// Reset is asynchronous, active low; doc_start clears the document state.
// A fingerprint waits in the output register; a new byte is taken meanwhile,
// and processing stalls only before writing a second fingerprint.
`default_nettype none

module winnowing_fingerprint_select_top
    import wfs_pkg::*;
#(
    parameter int KGRAM_LEN  = KGRAM_LEN_DEF,
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
)
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  cfg_write_en,
    input  wire [CFG_IDX_W-1:0]  cfg_index,
    input  wire [CFG_W-1:0]      cfg_data,
    input  wire                  in_valid,
    output logic                 in_stall,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  wire                  out_stall,
    output out_item_t            out_data
);

    cmd_t cmd;
    sts_t sts;
    logic in_ready;

    assign in_stall = !in_ready;

    wfs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    wfs_datapath #(
        .KGRAM_LEN  (KGRAM_LEN),
        .WINDOW_LEN (WINDOW_LEN)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data),
        .cmd          (cmd),
        .sts          (sts)
    );

    // A transfer starts work, so the next cycle is busy
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while a byte is in work");

    // A fingerprint never carries the empty-slot sentinel
    a_no_sentinel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.fp_hash != HASH_SENTINEL))
        else $error("sentinel emitted as fingerprint");

    // A new result only follows work on a byte
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without work");

endmodule

`default_nettype wire

// ===== hdl/wfs_ctrl.sv =====
// Sequencer for the winnowing fingerprint selector.
// Depends on wfs_pkg for command and status structs.
`default_nettype none

module wfs_ctrl
    import wfs_pkg::*;
(
    input  wire  clk,
    input  wire  rst_n,
    input  wire  in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_PRED   = 10'b0000000010,
        S_HRED   = 10'b0000000100,
        S_SRED   = 10'b0000001000,
        S_MUL2   = 10'b0000010000,
        S_FSTART = 10'b0000100000,
        S_FRED   = 10'b0001000000,
        S_UPD    = 10'b0010000000,
        S_SCANRD = 10'b0100000000,
        S_SCANCMP= 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic   emit_pend_reg, emit_pend_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            emit_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            emit_pend_reg <= emit_pend_next;
        end
    end

    // Ready only when idle and no result is still waiting for the output register
    assign in_ready = (state_reg == S_IDLE) && !emit_pend_reg;

    // Advance through the hash and window update steps
    always_comb
    begin
        state_next     = state_reg;
        emit_pend_next = emit_pend_reg;
        cmd            = '0;
        cmd.red_src    = SRC_POW;

        // Drain a pending fingerprint into the output register
        if (emit_pend_reg && sts.out_free)
        begin
            cmd.emit       = 1'b1;
            emit_pend_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !emit_pend_reg)
                begin
                    cmd.load      = 1'b1;
                    cmd.red_start = 1'b1;
                    cmd.red_src   = SRC_POW;
                    state_next    = S_PRED;
                end
            end
            S_PRED:
            begin
                if (!sts.red_busy)
                begin
                    cmd.mul1      = 1'b1;
                    cmd.red_start = 1'b1;
                    cmd.red_src   = SRC_CUR;
                    state_next    = S_HRED;
                end
            end
            S_HRED:
            begin
                if (!sts.red_busy)
                begin
                    cmd.cap_h = 1'b1;
                    if (sts.roll)
                    begin
                        cmd.red_start = 1'b1;
                        cmd.red_src   = SRC_PROD;
                        state_next    = S_SRED;
                    end
                    else
                    begin
                        state_next = S_MUL2;
                    end
                end
            end
            S_SRED:
            begin
                if (!sts.red_busy)
                begin
                    cmd.subc   = 1'b1;
                    state_next = S_MUL2;
                end
            end
            S_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_FSTART;
            end
            S_FSTART:
            begin
                cmd.red_start = 1'b1;
                cmd.red_src   = SRC_PROD;
                state_next    = S_FRED;
            end
            S_FRED:
            begin
                if (!sts.red_busy)
                begin
                    cmd.cap_fin = 1'b1;
                    state_next  = sts.kgram_full ? S_UPD : S_IDLE;
                end
            end
            S_UPD:
            begin
                cmd.upd = 1'b1;
                if (sts.min_hit)
                begin
                    state_next = S_SCANRD;
                end
                else
                begin
                    emit_pend_next = sts.new_le;
                    state_next     = S_IDLE;
                end
            end
            S_SCANRD:
            begin
                cmd.scan_rd = 1'b1;
                state_next  = S_SCANCMP;
            end
            S_SCANCMP:
            begin
                cmd.scan_cmp = 1'b1;
                if (sts.scan_last)
                begin
                    emit_pend_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    state_next = S_SCANRD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/wfs_datapath.sv =====
// Datapath: config registers, byte delay line, serial modular reducer,
// hash ring memory, window minimum tracking and output register. Uses wfs_pkg.
`default_nettype none

module wfs_datapath
    import wfs_pkg::*;
#(
    parameter int KGRAM_LEN  = KGRAM_LEN_DEF,
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
)
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   cfg_write_en,
    input  wire  [CFG_IDX_W-1:0]  cfg_index,
    input  wire  [CFG_W-1:0]      cfg_data,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  wire                   out_stall,
    output out_item_t             out_data,
    input  cmd_t                  cmd,
    output sts_t                  sts
);

    localparam int HW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam logic [HW-1:0]       W_LAST = HW'(WINDOW_LEN - 1);
    localparam logic [POS_BITS-1:0] K_POS  = POS_BITS'(KGRAM_LEN);
    localparam logic [POS_BITS-1:0] CNT_MAX = {POS_BITS{1'b1}};

    // Configuration
    logic [BASE_W-1:0] base_reg;
    logic [HASH_W-1:0] mod_reg;
    logic [HASH_W-1:0] pow_reg;
    logic [HASH_W-1:0] m_eff;

    // Per-document state
    logic [7:0]          dl_reg [KGRAM_LEN];
    logic [POS_BITS-1:0] cnt_reg, cnt_base, cnt_next;
    logic                roll_reg;
    logic [7:0]          byte_reg;
    logic [7:0]          leave_reg;
    logic [HASH_W-1:0]   cur_hash_reg;
    logic [HASH_W-1:0]   h_reg;
    logic [REDW-1:0]     prod_reg;

    // Serial reducer
    logic [REDW-1:0]     x_reg;
    logic [HASH_W-1:0]   r_reg;
    logic [RCNT_W-1:0]   rcnt_reg;
    logic [HASH_W:0]     r_shift;
    logic [HASH_W-1:0]   r_step;

    // Window
    logic [HASH_W-1:0]   ring_mem [WINDOW_LEN];
    logic                valid_reg [WINDOW_LEN];
    logic [HW-1:0]       head_reg, head_next;
    logic [HW-1:0]       minslot_reg;
    logic [HASH_W-1:0]   minval_reg;
    logic [HW-1:0]       mindist_reg;
    logic [HW-1:0]       j_reg;
    logic [HW-1:0]       d_reg;
    logic [HASH_W-1:0]   rd_reg;
    logic                rdv_reg;
    logic [HASH_W-1:0]   scan_val;

    logic [HASH_W:0]     sub_sum;
    logic [HASH_W-1:0]   sub_res;
    logic [38:0]         mul1_p;
    logic [46:0]         mul2_p;

    out_item_t           out_reg;
    logic                out_valid_reg;

    assign m_eff = (mod_reg < HASH_W'(2)) ? HASH_W'(2) : mod_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= HASH_BASE_RST;
            mod_reg  <= HASH_MODULUS_RST;
            pow_reg  <= BASE_POWER_RST;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_HASH_BASE:    base_reg <= cfg_data[BASE_W-1:0];
                REG_HASH_MODULUS: mod_reg  <= cfg_data;
                REG_BASE_POWER:   pow_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Byte count after this transfer, saturating
    assign cnt_base = in_data.doc_start ? '0 : cnt_reg;
    assign cnt_next = (cnt_base == CNT_MAX) ? cnt_base : cnt_base + POS_BITS'(1);

    // Shift the delay line and capture the input on a transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KGRAM_LEN; i++)
            begin
                dl_reg[i] <= '0;
            end
            cnt_reg      <= '0;
            roll_reg     <= 1'b0;
            byte_reg     <= '0;
            leave_reg    <= '0;
            cur_hash_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                leave_reg <= in_data.doc_start ? 8'd0 : dl_reg[KGRAM_LEN-1];
                for (int i = KGRAM_LEN - 1; i > 0; i--)
                begin
                    dl_reg[i] <= in_data.doc_start ? 8'd0 : dl_reg[i-1];
                end
                dl_reg[0] <= in_data.text_byte;
                byte_reg  <= in_data.text_byte;
                cnt_reg   <= cnt_next;
                roll_reg  <= (cnt_base >= K_POS);
                if (in_data.doc_start)
                begin
                    cur_hash_reg <= '0;
                end
            end
            else if (cmd.cap_fin)
            begin
                cur_hash_reg <= r_reg;
            end
        end
    end

    // Bit-serial restoring reduction of x_reg modulo m_eff
    assign r_shift = {r_reg, x_reg[REDW-1]};
    assign r_step  = (r_shift >= {1'b0, m_eff}) ? HASH_W'(r_shift - {1'b0, m_eff})
                                                 : r_shift[HASH_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rcnt_reg <= '0;
            r_reg    <= '0;
            x_reg    <= '0;
        end
        else if (cmd.red_start)
        begin
            rcnt_reg <= RCNT_W'(REDW);
            r_reg    <= '0;
            case (cmd.red_src)
                SRC_POW:  x_reg <= REDW'(pow_reg);
                SRC_CUR:  x_reg <= REDW'(cur_hash_reg);
                default:  x_reg <= prod_reg;
            endcase
        end
        else if (rcnt_reg != '0)
        begin
            rcnt_reg <= rcnt_reg - RCNT_W'(1);
            r_reg    <= r_step;
            x_reg    <= {x_reg[REDW-2:0], 1'b0};
        end
    end

    // Multiply steps and the modular subtract
    assign mul1_p  = leave_reg * r_reg;
    assign mul2_p  = h_reg * base_reg;
    assign sub_sum = {1'b0, h_reg} + {1'b0, m_eff} - {1'b0, r_reg};
    assign sub_res = (sub_sum >= {1'b0, m_eff}) ? HASH_W'(sub_sum - {1'b0, m_eff})
                                                : sub_sum[HASH_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.mul1)
        begin
            prod_reg <= REDW'(mul1_p);
        end
        else if (cmd.mul2)
        begin
            prod_reg <= REDW'(mul2_p) + REDW'(byte_reg);
        end

        if (cmd.cap_h || cmd.cap_fin)
        begin
            h_reg <= r_reg;
        end
        else if (cmd.subc)
        begin
            h_reg <= sub_res;
        end
    end

    // Ring memory: write the newest hash, read one entry a step during rescan
    assign head_next = (head_reg == W_LAST) ? '0 : head_reg + HW'(1);

    always_ff @(posedge clk)
    begin
        if (cmd.upd)
        begin
            ring_mem[head_next] <= h_reg;
        end
        if (cmd.scan_rd)
        begin
            rd_reg <= ring_mem[j_reg];
        end
    end

    // Track written slots; unwritten ones read as the sentinel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_LEN; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
            rdv_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load && in_data.doc_start)
            begin
                for (int i = 0; i < WINDOW_LEN; i++)
                begin
                    valid_reg[i] <= 1'b0;
                end
            end
            else if (cmd.upd)
            begin
                valid_reg[head_next] <= 1'b1;
            end
            if (cmd.scan_rd)
            begin
                rdv_reg <= valid_reg[j_reg];
            end
        end
    end

    assign scan_val = rdv_reg ? rd_reg : HASH_SENTINEL;

    // Maintain head, minimum slot and value, and the rescan walk
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            minslot_reg <= '0;
            minval_reg  <= HASH_SENTINEL;
            mindist_reg <= '0;
            j_reg       <= '0;
            d_reg       <= '0;
        end
        else if (cmd.load && in_data.doc_start)
        begin
            head_reg    <= '0;
            minslot_reg <= '0;
            minval_reg  <= HASH_SENTINEL;
            mindist_reg <= '0;
        end
        else if (cmd.upd)
        begin
            head_reg <= head_next;
            if (sts.min_hit || sts.new_le)
            begin
                minslot_reg <= head_next;
                minval_reg  <= h_reg;
                mindist_reg <= '0;
            end
            // Rescan starts one slot behind the new head
            j_reg <= head_reg;
            d_reg <= HW'(1);
        end
        else if (cmd.scan_cmp)
        begin
            if (scan_val < minval_reg)
            begin
                minslot_reg <= j_reg;
                minval_reg  <= scan_val;
                mindist_reg <= d_reg;
            end
            j_reg <= (j_reg == '0) ? W_LAST : j_reg - HW'(1);
            d_reg <= d_reg + HW'(1);
        end
    end

    // Hold the fingerprint until the downstream side takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_reg.fp_hash     <= minval_reg;
            out_reg.fp_position <= cnt_reg - K_POS - POS_BITS'(mindist_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Status back to the sequencer
    assign sts.red_busy   = (rcnt_reg != '0);
    assign sts.roll       = roll_reg;
    assign sts.kgram_full = (cnt_reg >= K_POS);
    assign sts.min_hit    = (minslot_reg == head_next);
    assign sts.new_le     = (h_reg <= minval_reg);
    assign sts.scan_last  = (d_reg == W_LAST);
    assign sts.out_free   = !out_valid_reg || !out_stall;

endmodule

`default_nettype wire

// ===== tb/sv/tb_winnowing_fingerprint_select_top.sv =====
// Testbench for winnowing_fingerprint_select_top: random byte streams with
// document restarts, checked against an in-bench winnowing predictor.
// Depends on wfs_pkg and the RTL of the selector.
`default_nettype none

module tb_winnowing_fingerprint_select_top;
    import wfs_pkg::*;

    localparam int KL = KGRAM_LEN_DEF;
    localparam int WL = WINDOW_LEN_DEF;
    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
    localparam int CYCLE_LIMIT = 3000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_item_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_item_t out_data;

    int error_count = 0;
    int cycle_count = 0;
    bit calm = 1'b0;
    bit drain_stall_en = 1'b1;

    winnowing_fingerprint_select_top dut (
        .clk(clk), .rst_n(rst_n), .cfg_write_en(cfg_write_en), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
        .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
        .out_data(out_data)
    );

    always #4 clk = ~clk;

    task automatic report_mismatch(input string what);
        $display("mismatch: %s", what);
        error_count++;
    endtask

    // Fingerprint predictor and store of pending fingerprints
    class fingerprint_board;
        logic [63:0] base, modulus, power;
        logic [7:0] bytes_q [KL];
        logic [63:0] ring [WL];
        logic [63:0] cur_hash;
        int head, min_at;
        logic [63:0] count;
        out_item_t pending [$];

        function void clear_doc();
            for (int i = 0; i < KL; i++) bytes_q[i] = 0;
            for (int i = 0; i < WL; i++) ring[i] = 64'h7FFF_FFFF;
            cur_hash = 0; head = 0; min_at = 0; count = 0;
        endfunction

        function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
            if (idx == REG_HASH_BASE) base = v[15:0];
            else if (idx == REG_HASH_MODULUS) modulus = v;
            else if (idx == REG_BASE_POWER) power = v;
        endfunction

        function void note_input(input in_item_t it);
            logic [63:0] m, p, h, span;
            logic [7:0] leaving;
            out_item_t r;
            m = (modulus < 2) ? 64'd2 : modulus;
            p = power % m;
            if (it.doc_start) clear_doc();
            leaving = bytes_q[KL-1];
            for (int i = KL - 1; i > 0; i--) bytes_q[i] = bytes_q[i-1];
            bytes_q[0] = it.text_byte;
            h = cur_hash % m;
            if (count >= KL) h = (h + m - (leaving * p) % m) % m;
            h = (h * base + it.text_byte) % m;
            cur_hash = h;
            if (count < POS_MAX) count++;
            if (count < KL) return;
            head = (head + 1) % WL;
            ring[head] = h;
            if (min_at == head) begin
                for (int j = (head + WL - 1) % WL; j != head; j = (j + WL - 1) % WL)
                    if (ring[j] < ring[min_at]) min_at = j;
                span = (head + WL - min_at) % WL;
                r.fp_hash = ring[min_at][30:0];
                r.fp_position = 24'(count - KL - span);
                pending = {pending, r};
            end else if (ring[head] <= ring[min_at]) begin
                min_at = head;
                r.fp_hash = h[30:0];
                r.fp_position = 24'(count - KL);
                pending = {pending, r};
            end
        endfunction

        task check_result(input out_item_t got);
            out_item_t want;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected fingerprint %h", got));
                return;
            end
            want = pending.pop_front();
            if (got.fp_hash !== want.fp_hash)
                report_mismatch($sformatf("fp_hash %0d want %0d", got.fp_hash, want.fp_hash));
            if (got.fp_position !== want.fp_position)
                report_mismatch($sformatf("fp_position %0d want %0d",
                    got.fp_position, want.fp_position));
        endtask
    endclass

    fingerprint_board board = new();

    // Count cycles, check transfers, stall the output side in bursts
    initial
    begin
        int hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
            if (rst_n && out_valid && !out_stall) board.check_result(out_data);
            if (hold > 0)
            begin
                hold--;
                out_stall <= 1'b1;
            end
            else if (!calm && drain_stall_en && $urandom_range(0, 7) == 0)
            begin
                hold = $urandom_range(1, 18);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        board.set_reg(idx, v);
    endtask

    // Hold off until all fingerprints have come and the block has settled
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic ds);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{text_byte: b, doc_start: ds};
        do @(posedge clk); while (in_stall);
        board.note_input('{text_byte: b, doc_start: ds});
    endtask

    // Modular power used to keep base_power consistent with the base
    function automatic logic [30:0] pow_mod(input logic [63:0] b, input logic [63:0] m);
        logic [63:0] r;
        r = 1 % m;
        for (int i = 0; i < KL - 1; i++) r = (r * b) % m;
        return r[30:0];
    endfunction

    task automatic config_set(input logic [15:0] b, input logic [30:0] m, input logic [30:0] p);
        write_reg(REG_HASH_BASE, 31'(b));
        write_reg(REG_HASH_MODULUS, m);
        write_reg(REG_BASE_POWER, p);
        cfg_write_en <= 1'b0;
    endtask

    initial
    begin
        logic [63:0] m;
        logic [15:0] b;
        board.base = HASH_BASE_RST;
        board.modulus = HASH_MODULUS_RST;
        board.power = BASE_POWER_RST;
        board.clear_doc();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset config, extreme bytes, restarts mid-warm-up
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        for (int i = 0; i < 12; i++) send_byte((i % 2) ? 8'hFF : 8'h00, 1'b0);
        send_byte(8'h80, 1'b1);
        for (int i = 0; i < 8; i++) send_byte(8'h41, 1'b0);
        wait_idle();

        // Random phases over several settings, extremes included
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: config_set(16'd2, 31'd2, 31'd0);
                1: config_set(16'hFFFF, 31'h7FFF_FFFF, pow_mod(64'hFFFF, 64'h7FFF_FFFF));
                2: config_set(16'd7, 31'd0, 31'h7FFF_FFFF);
                3: config_set(16'd3, 31'd1, 31'h1234_5678);
                4: config_set(16'd31, 31'd13, 31'h7FFF_FFFE);
                default:
                begin
                    b = $urandom_range(2, 65535);
                    m = (ph == 5) ? $urandom_range(2, 50) : $urandom_range(2, 31'h7FFF_FFFF);
                    config_set(b, m[30:0], ($urandom_range(0, 3) == 0) ?
                        31'($urandom) : pow_mod(b, m));
                end
            endcase
            if (ph == 7) calm = 1'b1;
            for (int n = 0; n < 230; n++)
            begin
                logic [7:0] v;
                case ($urandom_range(0, 3))
                    0: v = $urandom_range(0, 3);
                    1: v = 8'hFF - $urandom_range(0, 3);
                    default: v = $urandom;
                endcase
                send_byte(v, (n == 0) || ($urandom_range(0, 60) == 0));
                if (ph == 3 && n == 100)
                begin
                    // Pause input until every pending fingerprint has drained
                    in_valid <= 1'b0;
                    @(posedge clk);
                    while (board.pending.size() != 0) @(posedge clk);
                end
            end
            wait_idle();
        end

        // Position saturation is out of reach in cycle budget; end of run
        wait_idle();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

`default_nettype wire
